[hw/rtl/rmj_pkg.sv]
`timescale 1ns / 1ps
package rmj_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int DW   = DATA_WIDTH;
  localparam int SW   = 2 * DATA_WIDTH;
  localparam int QW   = DATA_WIDTH + 1;
  localparam int DENW = 3 * DATA_WIDTH;
  localparam int NUMW = 3 * DATA_WIDTH + FRAC_BITS;
  localparam int HW   = NUMW - QW;
  localparam int CMPW = (HW > DENW) ? HW : DENW;

  localparam int LANES   = 6;
  localparam int DIV_LAT = QW + 2;

  localparam logic [QW-1:0] SAT_HALF = QW'(1) << (DATA_WIDTH - 1);

  // lane order of the divider bank
  localparam int LANE_RNG_PX  = 0;
  localparam int LANE_RNG_PY  = 1;
  localparam int LANE_BRG_PX  = 2;
  localparam int LANE_BRG_PY  = 3;
  localparam int LANE_RATE_PX = 4;
  localparam int LANE_RATE_PY = 5;

  typedef struct packed {
    logic [DW-1:0] p_mag;
    logic [DW-1:0] q_mag;
    logic [SW-1:0] s;
    logic [SW-1:0] d_mag;
    logic          np;
    logic          nq;
    logic          nd;
    logic          zero;
  } jac_pre_t;

  typedef struct packed {
    logic [NUMW-1:0] num;
    logic [DENW-1:0] den;
    logic            neg;
  } div_req_t;

endpackage

[hw/rtl/rmj_front.sv]
`timescale 1ns / 1ps
module rmj_front import rmj_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [DW-1:0] pos_x,
  input  logic signed [DW-1:0] pos_y,
  input  logic signed [DW-1:0] vel_x,
  input  logic signed [DW-1:0] vel_y,
  output logic                 out_valid,
  output jac_pre_t             pre
);

  logic [2:0]    val_r;
  logic [DW-1:0] pm_r, qm_r, vxm_r, vym_r;
  logic          np_r, nq_r, nvx_r, nvy_r, zero1_r;
  logic [SW-1:0] pp_r, qq_r, t1_r, t2_r;
  logic [DW-1:0] pm2_r, qm2_r;
  logic          np2_r, nq2_r, s1_r, s2n_r, zero2_r;
  jac_pre_t      pre_r, pre_nxt;
  logic [SW-1:0] pp_nxt, qq_nxt, t1_nxt, t2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= {val_r[1:0], in_valid};
    end
  end

  // stage 1: sign and magnitude
  always_ff @(posedge clk) begin
    np_r    <= pos_x[DW-1];
    nq_r    <= pos_y[DW-1];
    nvx_r   <= vel_x[DW-1];
    nvy_r   <= vel_y[DW-1];
    pm_r    <= pos_x[DW-1] ? (~pos_x + 1'b1) : pos_x;
    qm_r    <= pos_y[DW-1] ? (~pos_y + 1'b1) : pos_y;
    vxm_r   <= vel_x[DW-1] ? (~vel_x + 1'b1) : vel_x;
    vym_r   <= vel_y[DW-1] ? (~vel_y + 1'b1) : vel_y;
    zero1_r <= (pos_x == '0) && (pos_y == '0);
  end

  // stage 2: four products
  assign pp_nxt = pm_r * pm_r;
  assign qq_nxt = qm_r * qm_r;
  assign t1_nxt = vxm_r * qm_r;
  assign t2_nxt = vym_r * pm_r;

  always_ff @(posedge clk) begin
    pp_r    <= pp_nxt;
    qq_r    <= qq_nxt;
    t1_r    <= t1_nxt;
    t2_r    <= t2_nxt;
    pm2_r   <= pm_r;
    qm2_r   <= qm_r;
    np2_r   <= np_r;
    nq2_r   <= nq_r;
    s1_r    <= nvx_r ^ nq_r;
    s2n_r   <= ~(nvy_r ^ np_r);
    zero2_r <= zero1_r;
  end

  // stage 3: range squared and signed cross term
  always_comb begin
    pre_nxt       = '0;
    pre_nxt.p_mag = pm2_r;
    pre_nxt.q_mag = qm2_r;
    pre_nxt.s     = pp_r + qq_r;
    pre_nxt.np    = np2_r;
    pre_nxt.nq    = nq2_r;
    pre_nxt.zero  = zero2_r;
    if (s1_r == s2n_r) begin
      pre_nxt.d_mag = t1_r + t2_r;
      pre_nxt.nd    = s1_r;
    end else if (t1_r >= t2_r) begin
      pre_nxt.d_mag = t1_r - t2_r;
      pre_nxt.nd    = s1_r;
    end else begin
      pre_nxt.d_mag = t2_r - t1_r;
      pre_nxt.nd    = s2n_r;
    end
  end

  always_ff @(posedge clk) begin
    pre_r <= pre_nxt;
  end

  assign pre       = pre_r;
  assign out_valid = val_r[2];

endmodule

[hw/rtl/rmj_isqrt.sv]
`timescale 1ns / 1ps
module rmj_isqrt import rmj_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  jac_pre_t      pre_in,
  output logic          out_valid,
  output jac_pre_t      pre_out,
  output logic [DW-1:0] root
);

  logic [DW:1]   val_r;
  logic [SW-1:0] rem_r   [1:DW];
  logic [SW-1:0] rem_nxt [1:DW];
  logic [DW-1:0] root_r  [1:DW];
  logic [DW-1:0] root_nxt[1:DW];
  jac_pre_t      pay_r   [1:DW];
  logic [SW-1:0] st_rem  [0:DW-1];
  logic [DW-1:0] st_root [0:DW-1];

  always_comb begin
    st_rem[0]  = pre_in.s;
    st_root[0] = '0;
    for (int k = 1; k < DW; k++) begin
      st_rem[k]  = rem_r[k];
      st_root[k] = root_r[k];
    end
  end

  // one root bit per stage, remainder kept as s minus root squared
  always_comb begin
    logic [SW:0] trial;
    for (int k = 0; k < DW; k++) begin
      trial = ((SW + 1)'(st_root[k]) << (DW - k)) + ((SW + 1)'(1) << (2 * (DW - 1 - k)));
      if ({1'b0, st_rem[k]} >= trial) begin
        rem_nxt[k+1]  = st_rem[k] - trial[SW-1:0];
        root_nxt[k+1] = st_root[k] | (DW'(1) << (DW - 1 - k));
      end else begin
        rem_nxt[k+1]  = st_rem[k];
        root_nxt[k+1] = st_root[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= {val_r[DW-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    pay_r[1] <= pre_in;
    for (int k = 1; k <= DW; k++) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
    end
    for (int k = 2; k <= DW; k++) begin
      pay_r[k] <= pay_r[k-1];
    end
  end

  assign out_valid = val_r[DW];
  assign pre_out   = pay_r[DW];
  assign root      = root_r[DW];

endmodule

[hw/rtl/rmj_mid.sv]
`timescale 1ns / 1ps
module rmj_mid import rmj_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  jac_pre_t                   pre,
  input  logic [DW-1:0]              root,
  output logic                       out_valid,
  output logic                       zero,
  output div_req_t [LANES-1:0]       req
);

  logic [1:0]      val_r;
  logic [SW-1:0]   qdl_r, qdh_r, pdl_r, pdh_r, srl_r, srh_r;
  logic [SW-1:0]   qdl_nxt, qdh_nxt, pdl_nxt, pdh_nxt, srl_nxt, srh_nxt;
  jac_pre_t        pre1_r, pre2_r;
  logic [DW-1:0]   root1_r, root2_r;
  logic [DENW-1:0] qd_r, pd_r, sr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= {val_r[0], in_valid};
    end
  end

  // partial products, one half of the wide operand each
  assign qdl_nxt = pre.q_mag * pre.d_mag[DW-1:0];
  assign qdh_nxt = pre.q_mag * pre.d_mag[SW-1:DW];
  assign pdl_nxt = pre.p_mag * pre.d_mag[DW-1:0];
  assign pdh_nxt = pre.p_mag * pre.d_mag[SW-1:DW];
  assign srl_nxt = pre.s[DW-1:0] * root;
  assign srh_nxt = pre.s[SW-1:DW] * root;

  always_ff @(posedge clk) begin
    qdl_r   <= qdl_nxt;
    qdh_r   <= qdh_nxt;
    pdl_r   <= pdl_nxt;
    pdh_r   <= pdh_nxt;
    srl_r   <= srl_nxt;
    srh_r   <= srh_nxt;
    pre1_r  <= pre;
    root1_r <= root;
    qd_r    <= DENW'(qdl_r) + (DENW'(qdh_r) << DW);
    pd_r    <= DENW'(pdl_r) + (DENW'(pdh_r) << DW);
    sr_r    <= DENW'(srl_r) + (DENW'(srh_r) << DW);
    pre2_r  <= pre1_r;
    root2_r <= root1_r;
  end

  always_comb begin
    req[LANE_RNG_PX].num  = NUMW'(pre2_r.p_mag) << FRAC_BITS;
    req[LANE_RNG_PX].den  = DENW'(root2_r);
    req[LANE_RNG_PX].neg  = pre2_r.np;
    req[LANE_RNG_PY].num  = NUMW'(pre2_r.q_mag) << FRAC_BITS;
    req[LANE_RNG_PY].den  = DENW'(root2_r);
    req[LANE_RNG_PY].neg  = pre2_r.nq;
    req[LANE_BRG_PX].num  = NUMW'(pre2_r.q_mag) << (2 * FRAC_BITS);
    req[LANE_BRG_PX].den  = DENW'(pre2_r.s);
    req[LANE_BRG_PX].neg  = ~pre2_r.nq;
    req[LANE_BRG_PY].num  = NUMW'(pre2_r.p_mag) << (2 * FRAC_BITS);
    req[LANE_BRG_PY].den  = DENW'(pre2_r.s);
    req[LANE_BRG_PY].neg  = pre2_r.np;
    req[LANE_RATE_PX].num = NUMW'(qd_r) << FRAC_BITS;
    req[LANE_RATE_PX].den = sr_r;
    req[LANE_RATE_PX].neg = pre2_r.nq ^ pre2_r.nd;
    req[LANE_RATE_PY].num = NUMW'(pd_r) << FRAC_BITS;
    req[LANE_RATE_PY].den = sr_r;
    req[LANE_RATE_PY].neg = ~(pre2_r.np ^ pre2_r.nd);
  end

  assign zero      = pre2_r.zero;
  assign out_valid = val_r[1];

endmodule

[hw/rtl/rmj_div_pipe.sv]
`timescale 1ns / 1ps
module rmj_div_pipe import rmj_pkg::*; (
  input  logic                 clk,
  input  div_req_t             req,
  output logic signed [DW-1:0] quot
);

  logic [DENW-1:0] rem_r   [0:QW];
  logic [DENW-1:0] rem_nxt [1:QW];
  logic [QW-1:0]   sh_r    [0:QW];
  logic [QW-1:0]   sh_nxt  [1:QW];
  logic [DENW-1:0] den_r   [0:QW];
  logic            neg_r   [0:QW];
  logic            ovf_r   [0:QW];
  logic [HW-1:0]   head;
  logic            ovf_nxt;
  logic [QW-1:0]   mag;
  logic [QW-1:0]   negmag;
  logic [DW-1:0]   quot_nxt;
  logic [DW-1:0]   quot_r;

  // quotient wider than QW bits means saturation anyway
  assign head    = req.num[NUMW-1:QW];
  assign ovf_nxt = CMPW'(head) >= CMPW'(req.den);

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [DENW:0] tr;
    logic [DENW:0] diff;
    for (int k = 1; k <= QW; k++) begin
      tr   = {rem_r[k-1], sh_r[k-1][QW-1]};
      diff = tr - {1'b0, den_r[k-1]};
      if (tr >= {1'b0, den_r[k-1]}) begin
        rem_nxt[k] = diff[DENW-1:0];
        sh_nxt[k]  = {sh_r[k-1][QW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = tr[DENW-1:0];
        sh_nxt[k]  = {sh_r[k-1][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= ovf_nxt ? '0 : DENW'(head);
    sh_r[0]  <= req.num[QW-1:0];
    den_r[0] <= req.den;
    neg_r[0] <= req.neg;
    ovf_r[0] <= ovf_nxt;
    for (int k = 1; k <= QW; k++) begin
      rem_r[k] <= rem_nxt[k];
      sh_r[k]  <= sh_nxt[k];
      den_r[k] <= den_r[k-1];
      neg_r[k] <= neg_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
    end
  end

  // saturate to the signed output range
  always_comb begin
    if (neg_r[QW]) begin
      mag = (ovf_r[QW] || (sh_r[QW] > SAT_HALF)) ? SAT_HALF : sh_r[QW];
    end else begin
      mag = (ovf_r[QW] || (sh_r[QW] > (SAT_HALF - 1'b1))) ? (SAT_HALF - 1'b1) : sh_r[QW];
    end
    negmag   = ~mag + 1'b1;
    quot_nxt = neg_r[QW] ? negmag[DW-1:0] : mag[DW-1:0];
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
  end

  assign quot = quot_r;

endmodule

[hw/rtl/radar_measurement_jacobian.sv]
`timescale 1ns / 1ps
// radar measurement jacobian: for each track state beat (pos_x, pos_y, vel_x,
// vel_y, signed q16.16) gives px/rho, py/rho, -py/rho^2, px/rho^2 and the two
// range-rate partials, saturated to q16.16. a zero position gives all-zero
// entries and zero_range_error. a new beat is taken every cycle (busy stays
// low) and each result appears on the out_ ports for one cycle with
// out_valid, in order. the receiver cannot stall, so results must be
// captured when strobed. each beat passes the front registers, the
// bit-per-stage square root (DATA_WIDTH stages), the multiply registers, the
// bit-per-stage divider bank (DATA_WIDTH+3 stages) and the output registers.
module radar_measurement_jacobian import rmj_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [DW-1:0] in_pos_x,
  input  logic signed [DW-1:0] in_pos_y,
  input  logic signed [DW-1:0] in_vel_x,
  input  logic signed [DW-1:0] in_vel_y,
  output logic                 out_valid,
  output logic signed [DW-1:0] out_range_d_px,
  output logic signed [DW-1:0] out_range_d_py,
  output logic signed [DW-1:0] out_bearing_d_px,
  output logic signed [DW-1:0] out_bearing_d_py,
  output logic signed [DW-1:0] out_rate_d_px,
  output logic signed [DW-1:0] out_rate_d_py,
  output logic                 out_zero_range_error
);

  logic                 fr_valid;
  jac_pre_t             fr_pre;
  logic                 sq_valid;
  jac_pre_t             sq_pre;
  logic [DW-1:0]        sq_root;
  logic                 md_valid;
  logic                 md_zero;
  div_req_t [LANES-1:0] md_req;
  logic signed [DW-1:0] quot [LANES];

  // valid and zero flag ride alongside the divider bank
  logic [DIV_LAT-1:0]   val_d_r;
  logic [DIV_LAT-1:0]   zero_d_r;

  logic                 out_valid_r;
  logic                 zero_out_r;
  logic signed [DW-1:0] ent_r [LANES];

  // fully pipelined, never holds off a start beat
  assign busy = 1'b0;

  // sign split, squares, cross term
  rmj_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .pos_x     (in_pos_x),
    .pos_y     (in_pos_y),
    .vel_x     (in_vel_x),
    .vel_y     (in_vel_y),
    .out_valid (fr_valid),
    .pre       (fr_pre)
  );

  // rho = floor(sqrt(px^2 + py^2))
  rmj_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .pre_in    (fr_pre),
    .out_valid (sq_valid),
    .pre_out   (sq_pre),
    .root      (sq_root)
  );

  // numerators and denominators for the six entries
  rmj_mid u_mid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .pre       (sq_pre),
    .root      (sq_root),
    .out_valid (md_valid),
    .zero      (md_zero),
    .req       (md_req)
  );

  // one divider lane per entry, all in lockstep
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    rmj_div_pipe u_div (
      .clk  (clk),
      .req  (md_req[i]),
      .quot (quot[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_d_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      val_d_r     <= {val_d_r[DIV_LAT-2:0], md_valid};
      out_valid_r <= val_d_r[DIV_LAT-1];
    end
  end

  // zero range forces every entry to zero
  always_ff @(posedge clk) begin
    zero_d_r   <= {zero_d_r[DIV_LAT-2:0], md_zero};
    zero_out_r <= zero_d_r[DIV_LAT-1];
    for (int i = 0; i < LANES; i++) begin
      ent_r[i] <= zero_d_r[DIV_LAT-1] ? '0 : quot[i];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_zero_range_error = zero_out_r;
  assign out_range_d_px       = ent_r[LANE_RNG_PX];
  assign out_range_d_py       = ent_r[LANE_RNG_PY];
  assign out_bearing_d_px     = ent_r[LANE_BRG_PX];
  assign out_bearing_d_py     = ent_r[LANE_BRG_PY];
  assign out_rate_d_px        = ent_r[LANE_RATE_PX];
  assign out_rate_d_py        = ent_r[LANE_RATE_PY];

endmodule

[test/jacobian_checker.sv]
`timescale 1ns / 1ps
module jacobian_checker import rmj_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic signed [DW-1:0] in_pos_x,
  input  logic signed [DW-1:0] in_pos_y,
  input  logic signed [DW-1:0] in_vel_x,
  input  logic signed [DW-1:0] in_vel_y,
  input  logic                 out_valid,
  input  logic signed [DW-1:0] out_range_d_px,
  input  logic signed [DW-1:0] out_range_d_py,
  input  logic signed [DW-1:0] out_bearing_d_px,
  input  logic signed [DW-1:0] out_bearing_d_py,
  input  logic signed [DW-1:0] out_rate_d_px,
  input  logic signed [DW-1:0] out_rate_d_py,
  input  logic                 out_zero_range_error,
  output int                   fail_count,
  output int                   pending,
  output int                   checked
);

  localparam int BW = 192;

  typedef struct {
    logic signed [DW-1:0] rng_px;
    logic signed [DW-1:0] rng_py;
    logic signed [DW-1:0] brg_px;
    logic signed [DW-1:0] brg_py;
    logic signed [DW-1:0] rate_px;
    logic signed [DW-1:0] rate_py;
    logic                 zero;
  } jacobian_t;

  jacobian_t jacobian_q[$];

  function automatic logic [BW-1:0] magnitude(logic signed [127:0] v);
    return (v < 0) ? BW'(-v) : BW'(v);
  endfunction

  // truncated quotient, saturated to the signed entry range
  function automatic logic [DW-1:0] sat_quot(logic [BW-1:0] num, logic [BW-1:0] den,
                                            bit neg);
    logic [BW-1:0] q;
    logic [BW-1:0] half;
    half = BW'(1) << (DW - 1);
    q = num / den;
    if (neg) begin
      if (q > half) q = half;
      return DW'(-q);
    end
    if (q > half - 1) q = half - 1;
    return DW'(q);
  endfunction

  function automatic jacobian_t predict_jacobian(logic signed [DW-1:0] px,
                                                 logic signed [DW-1:0] py,
                                                 logic signed [DW-1:0] vx,
                                                 logic signed [DW-1:0] vy);
    jacobian_t j;
    logic signed [127:0] dsg;
    logic [BW-1:0] pm, qm, s, r, c, dm, den;
    bit np, nq, nd;
    np = px < 0;
    nq = py < 0;
    pm = magnitude(128'(px));
    qm = magnitude(128'(py));
    j = '{default: '0};
    if (pm == 0 && qm == 0) begin
      j.zero = 1'b1;
      return j;
    end
    s = pm * pm + qm * qm;
    r = '0;
    for (int b = DW + 1; b >= 0; b--) begin
      c = r | (BW'(1) << b);
      if (c * c <= s) r = c;
    end
    dsg = 128'(vx) * 128'(py) - 128'(vy) * 128'(px);
    nd = dsg < 0;
    dm = magnitude(dsg);
    den = s * r;
    j.rng_px  = sat_quot(pm << FRAC_BITS, r, np);
    j.rng_py  = sat_quot(qm << FRAC_BITS, r, nq);
    j.brg_px  = sat_quot(qm << (2 * FRAC_BITS), s, !nq);
    j.brg_py  = sat_quot(pm << (2 * FRAC_BITS), s, np);
    j.rate_px = sat_quot((qm * dm) << FRAC_BITS, den, nq != nd);
    j.rate_py = sat_quot((pm * dm) << FRAC_BITS, den, np == nd);
    return j;
  endfunction

  task automatic report_mismatch(string field, logic [DW-1:0] got, logic [DW-1:0] exp_v);
    $display("[%0t] mismatch on %s: got %h expected %h", $time, field, got, exp_v);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    checked = 0;
  end

  assign pending = jacobian_q.size();

  always @(posedge clk) begin
    jacobian_t e;
    if (rst_n) begin
      if (start && !busy)
        jacobian_q.push_back(predict_jacobian(in_pos_x, in_pos_y, in_vel_x, in_vel_y));
      if (out_valid) begin
        if (jacobian_q.size() == 0) begin
          $display("[%0t] result beat with nothing expected", $time);
          fail_count++;
        end else begin
          e = jacobian_q.pop_front();
          checked++;
          if (out_range_d_px !== e.rng_px) report_mismatch("range_d_px", out_range_d_px, e.rng_px);
          if (out_range_d_py !== e.rng_py) report_mismatch("range_d_py", out_range_d_py, e.rng_py);
          if (out_bearing_d_px !== e.brg_px)
            report_mismatch("bearing_d_px", out_bearing_d_px, e.brg_px);
          if (out_bearing_d_py !== e.brg_py)
            report_mismatch("bearing_d_py", out_bearing_d_py, e.brg_py);
          if (out_rate_d_px !== e.rate_px) report_mismatch("rate_d_px", out_rate_d_px, e.rate_px);
          if (out_rate_d_py !== e.rate_py) report_mismatch("rate_d_py", out_rate_d_py, e.rate_py);
          if (out_zero_range_error !== e.zero)
            report_mismatch("zero_range_error", DW'(out_zero_range_error), DW'(e.zero));
        end
      end
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import rmj_pkg::*;

  // generous bound: 818 beats plus idles and the pipeline depth
  localparam int CYCLE_LIMIT = 100000;
  localparam int N_RANDOM    = 800;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [DW-1:0] in_pos_x, in_pos_y, in_vel_x, in_vel_y;
  logic out_valid;
  logic signed [DW-1:0] out_range_d_px, out_range_d_py;
  logic signed [DW-1:0] out_bearing_d_px, out_bearing_d_py;
  logic signed [DW-1:0] out_rate_d_px, out_rate_d_py;
  logic out_zero_range_error;
  int fail_count, pending, checked;
  int cycles;

  localparam logic signed [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE_Q = DW'(1) << FRAC_BITS;

  radar_measurement_jacobian i_dut (.*);

  jacobian_checker i_checker (.*);

  // clock, 2 ns period
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one track state beat: present at the falling edge, hold until taken
  task automatic send_state(logic signed [DW-1:0] px, logic signed [DW-1:0] py,
                            logic signed [DW-1:0] vx, logic signed [DW-1:0] vy);
    start    <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_vel_x <= vx;
    in_vel_y <= vy;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // random idle cycles between beats, skipped in the quiet stretch
  task automatic maybe_idle(bit quiet);
    if (!quiet) begin
      while ($urandom_range(99) < 20) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
  endtask

  function automatic logic signed [DW-1:0] rnd_word();
    return DW'($urandom());
  endfunction

  // magnitudes spread over many scales so entries often stay unsaturated
  function automatic logic signed [DW-1:0] rnd_scaled();
    logic signed [DW-1:0] v;
    v = rnd_word() >>> $urandom_range(DW - 1);
    return v;
  endfunction

  initial begin
    logic signed [DW-1:0] px, py;
    bit quiet;
    start    = 1'b0;
    rst_n    = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_vel_x = '0;
    in_vel_y = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero range, axis points, extremes, saturation corners
    send_state('0, '0, MAX_V, MIN_V);
    send_state('0, '0, '0, '0);
    send_state(ONE_Q, '0, ONE_Q, ONE_Q);
    send_state('0, ONE_Q, -ONE_Q, ONE_Q);
    send_state(DW'(1), '0, MAX_V, MAX_V);
    send_state('0, DW'(-1), MIN_V, MAX_V);
    send_state(DW'(1), DW'(1), MIN_V, MIN_V);
    send_state(MAX_V, MAX_V, MAX_V, MIN_V);
    send_state(MIN_V, MIN_V, MIN_V, MAX_V);
    send_state(MIN_V, MAX_V, MAX_V, MAX_V);
    send_state(MAX_V, MIN_V, MIN_V, MIN_V);
    send_state(MIN_V, '0, '0, MAX_V);
    send_state('0, MIN_V, MAX_V, '0);
    send_state(3 * ONE_Q, 4 * ONE_Q, ONE_Q, -2 * ONE_Q);
    send_state(-3 * ONE_Q, 4 * ONE_Q, 5 * ONE_Q, 5 * ONE_Q);
    send_state(DW'(-1), DW'(-1), DW'(-1), DW'(-1));
    send_state(DW'(2), DW'(-3), MAX_V, MIN_V);
    send_state(ONE_Q, ONE_Q, '0, '0);

    // random: full-range words, scaled magnitudes, axis and zero positions
    for (int i = 0; i < N_RANDOM; i++) begin
      quiet = (i >= 300 && i < 450);
      maybe_idle(quiet);
      case ($urandom_range(9))
        0, 1, 2: begin
          px = rnd_word();
          py = rnd_word();
        end
        3: begin
          px = '0;
          py = '0;
        end
        4: begin
          px = $urandom_range(1) ? '0 : rnd_scaled();
          py = (px == 0) ? rnd_scaled() : '0;
        end
        default: begin
          px = rnd_scaled();
          py = rnd_scaled();
        end
      endcase
      send_state(px, py, $urandom_range(1) ? rnd_word() : rnd_scaled(),
                 $urandom_range(1) ? rnd_word() : rnd_scaled());
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("checked %0d jacobian results: zero range, axis points, saturation extremes",
             checked);
    $display("and full-range random track states with and without input idles");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
